// ----- design/assert_macros.svh -----
// assertion macros for the dispatcher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- design/mlqd_pkg.sv -----
// ----------------------------------------------------------------------------
// mlqd_pkg
// types and constants of the multilevel queue dispatcher
// ----------------------------------------------------------------------------
package mlqd_pkg;
   localparam int NUM_LEVELS = 8;
   localparam int FIFO_DEPTH = 16;
   localparam int NUM_CPUS   = 4;
   localparam int ID_BITS    = 8;
   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int SLOT_W = 9;
   localparam int ADDR_W = LVL_W + PTR_W;

   localparam logic FUNC_ENQUEUE  = 1'b0;
   localparam logic FUNC_DISPATCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [ID_BITS-1:0] wdata;
      logic               re;
      logic [ADDR_W-1:0]  raddr;
   } mem_ctl_type;
endpackage

// ----- design/mlqd_if.sv -----
// ----------------------------------------------------------------------------
// mlqd_req_if / mlqd_rsp_if
// valid-ready channels of the dispatcher
// ----------------------------------------------------------------------------
interface mlqd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] process_id;
   logic [2:0] priority_req;
   logic [1:0] cpu_index;
   modport source (output valid, func, process_id, priority_req, cpu_index, input ready);
   modport sink (input valid, func, process_id, priority_req, cpu_index, output ready);
endinterface

interface mlqd_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [7:0] granted_id;
   logic       all_empty;
   logic       enqueue_dropped;
   modport source (output valid, found, granted_id, all_empty, enqueue_dropped, input ready);
   modport sink (input valid, found, granted_id, all_empty, enqueue_dropped, output ready);
endinterface

// ----- design/multilevel_queue_dispatcher_top.sv -----
// ----------------------------------------------------------------------------
// multilevel_queue_dispatcher_top
// per-level id fifos with weighted round-robin dispatch across cpus
// ----------------------------------------------------------------------------
// Each request is handled in steps: on transfer the level is selected from the
// non-empty mask with a rotating priority encoder and the id memory access is
// issued, the registered memory read follows, then the result sits in the
// output register. A new request is taken only when the result has been
// transferred. The id memory needs no clearing after reset.
`include "assert_macros.svh"
module multilevel_queue_dispatcher_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   mlqd_req_if.sink   req,
   mlqd_rsp_if.source rsp
);
   localparam int NL = mlqd_pkg::NUM_LEVELS;
   localparam int LW = mlqd_pkg::LVL_W;

   mlqd_pkg::state_type state_ff, state_in;
   logic [7:0] inc_ff;
   logic [mlqd_pkg::PTR_W-1:0] head_ff [NL];
   logic [mlqd_pkg::CNT_W-1:0] count_ff [NL];
   logic [mlqd_pkg::SLOT_W-1:0] slot_ff [NL];
   logic [LW-1:0] cursor_ff [mlqd_pkg::NUM_CPUS];
   logic found_ff, found_in, drop_ff, drop_in, empty_ff;
   logic [7:0] gid_ff;
   mlqd_pkg::mem_ctl_type ctl;
   logic [mlqd_pkg::ID_BITS-1:0] rdata;
   logic [NL-1:0] nonempty;
   logic [LW-1:0] start, pick;
   logic hit, accept;

   mlqd_store u_store (.clock(clock), .ctl(ctl), .rdata(rdata));

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == mlqd_pkg::ST_IDLE);
   assign rsp.valid = (state_ff == mlqd_pkg::ST_OUT);
   assign rsp.found = found_ff;
   assign rsp.granted_id = gid_ff;
   assign rsp.all_empty = empty_ff;
   assign rsp.enqueue_dropped = drop_ff;

   always_comb begin
      for (int i = 0; i < NL; i++) nonempty[i] = (count_ff[i] != '0);
      start = cursor_ff[req.cpu_index];
      hit = 1'b0;
      pick = '0;
      for (int k = NL - 1; k >= 0; k--) begin
         if (nonempty[LW'((32'(start) + k) % NL)]) begin
            hit = 1'b1;
            pick = LW'((32'(start) + k) % NL);
         end
      end
   end

   logic [LW-1:0] plvl;
   logic prio_ok, full;
   logic [mlqd_pkg::SLOT_W-1:0] slot_sum;
   always_comb begin
      plvl = LW'(req.priority_req);
      prio_ok = (32'(req.priority_req) < NL);
      full = !prio_ok || (32'(count_ff[plvl]) >= mlqd_pkg::FIFO_DEPTH);
      ctl.we = accept && req.func == mlqd_pkg::FUNC_ENQUEUE && !full;
      ctl.waddr = {plvl, mlqd_pkg::PTR_W'(head_ff[plvl] + count_ff[plvl])};
      ctl.wdata = mlqd_pkg::ID_BITS'(req.process_id);
      ctl.re = accept && req.func == mlqd_pkg::FUNC_DISPATCH && hit;
      ctl.raddr = {pick, head_ff[pick]};
      slot_sum = slot_ff[pick] + mlqd_pkg::SLOT_W'(inc_ff);
      found_in = req.func == mlqd_pkg::FUNC_DISPATCH && hit
                 && (32'(req.cpu_index) < mlqd_pkg::NUM_CPUS);
      drop_in = req.func == mlqd_pkg::FUNC_ENQUEUE && full;
      state_in = state_ff;
      case (state_ff)
         mlqd_pkg::ST_IDLE: if (accept) state_in = mlqd_pkg::ST_READ;
         mlqd_pkg::ST_READ: state_in = mlqd_pkg::ST_OUT;
         mlqd_pkg::ST_OUT:  if (rsp.ready) state_in = mlqd_pkg::ST_IDLE;
         default: state_in = mlqd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlqd_pkg::ST_IDLE;
         inc_ff <= 8'd1;
         for (int i = 0; i < NL; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
            slot_ff[i] <= '0;
         end
         for (int c = 0; c < mlqd_pkg::NUM_CPUS; c++) cursor_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) inc_ff <= csr_wdata;
         if (ctl.we) count_ff[plvl] <= count_ff[plvl] + 1'b1;
         if (accept && req.func == mlqd_pkg::FUNC_DISPATCH
             && 32'(req.cpu_index) < mlqd_pkg::NUM_CPUS) begin
            if (hit) begin
               head_ff[pick] <= mlqd_pkg::PTR_W'(head_ff[pick] + 1'b1);
               count_ff[pick] <= count_ff[pick] - 1'b1;
               if (32'(slot_sum) >= NL - 32'(pick) || count_ff[pick] == 1) begin
                  slot_ff[pick] <= '0;
                  cursor_ff[req.cpu_index] <= LW'((32'(pick) + 1) % NL);
               end else begin
                  slot_ff[pick] <= slot_sum;
                  cursor_ff[req.cpu_index] <= pick;
               end
            end else begin
               cursor_ff[req.cpu_index] <= '0;
            end
         end
      end
   end

   logic re_d_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff <= found_in;
         drop_ff <= drop_in;
      end
      re_d_ff <= ctl.re && found_in;
      if (state_ff == mlqd_pkg::ST_READ) begin
         gid_ff <= re_d_ff ? 8'(rdata) : 8'd0;
         empty_ff <= (nonempty == '0);
      end
   end

   `ASSERT_CLK(a_ready_idle, clock, reset, accept |=> state_ff == mlqd_pkg::ST_READ, "no read")
   `ASSERT_CLK(a_one_access, clock, reset, !(ctl.we && ctl.re), "two accesses")
   `ASSERT_CLK(a_hold, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid, "out lost")
endmodule

// ----- design/mlqd_store.sv -----
// ----------------------------------------------------------------------------
// mlqd_store
// id memory of all level fifos, one write and one registered read port
// ----------------------------------------------------------------------------
module mlqd_store (
   input  logic                         clock,
   input  mlqd_pkg::mem_ctl_type        ctl,
   output logic [mlqd_pkg::ID_BITS-1:0] rdata
);
   logic [mlqd_pkg::ID_BITS-1:0] mem [mlqd_pkg::NUM_LEVELS*mlqd_pkg::FIFO_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rdata <= mem[ctl.raddr];
      end
   end
endmodule

// ----- tb/mlqd_checker.sv -----
// ----------------------------------------------------------------------------
// mlqd_checker
// predicts dispatcher results from observed request transfers and compares
// them, field by field, with the result transfers
// ----------------------------------------------------------------------------
module mlqd_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   mlqd_req_if        req,
   mlqd_rsp_if        rsp,
   output int         fail_count,
   output int         pending_count
);
   typedef struct packed {
      logic       found;
      logic [7:0] granted_id;
      logic       all_empty;
      logic       enqueue_dropped;
   } disp_result_type;

   logic [mlqd_pkg::ID_BITS-1:0] id_store [mlqd_pkg::NUM_LEVELS*mlqd_pkg::FIFO_DEPTH];
   logic [mlqd_pkg::PTR_W-1:0]   head_ptr [mlqd_pkg::NUM_LEVELS];
   int                           depth_used [mlqd_pkg::NUM_LEVELS];
   int                           slot_used [mlqd_pkg::NUM_LEVELS];
   int                           cursor [mlqd_pkg::NUM_CPUS];
   int                           slot_inc;
   disp_result_type              expected_q [$];

   function automatic disp_result_type predict_dispatch(logic func, logic [7:0] pid,
                                                        logic [2:0] prio, logic [1:0] cpu);
      disp_result_type r;
      int              lvl;
      int              start;
      r = '0;
      if (func == mlqd_pkg::FUNC_ENQUEUE) begin
         if (prio >= mlqd_pkg::NUM_LEVELS || depth_used[prio] >= mlqd_pkg::FIFO_DEPTH) begin
            r.enqueue_dropped = 1'b1;
         end else begin
            id_store[prio*mlqd_pkg::FIFO_DEPTH
                     + (head_ptr[prio] + depth_used[prio]) % mlqd_pkg::FIFO_DEPTH] = pid;
            depth_used[prio]++;
         end
      end else if (cpu < mlqd_pkg::NUM_CPUS) begin
         start = cursor[cpu] % mlqd_pkg::NUM_LEVELS;
         for (int k = 0; k < mlqd_pkg::NUM_LEVELS; k++) begin
            lvl = (start + k) % mlqd_pkg::NUM_LEVELS;
            if (!r.found && depth_used[lvl] != 0) begin
               r.found = 1'b1;
               r.granted_id = id_store[lvl*mlqd_pkg::FIFO_DEPTH + head_ptr[lvl]];
               head_ptr[lvl] = head_ptr[lvl] + 1'b1;
               depth_used[lvl]--;
               slot_used[lvl] += slot_inc;
               cursor[cpu] = lvl;
               if (slot_used[lvl] >= mlqd_pkg::NUM_LEVELS - lvl || depth_used[lvl] == 0) begin
                  slot_used[lvl] = 0;
                  cursor[cpu] = (lvl + 1) % mlqd_pkg::NUM_LEVELS;
               end
            end
         end
         if (!r.found) cursor[cpu] = 0;
      end
      r.all_empty = 1'b1;
      for (int l = 0; l < mlqd_pkg::NUM_LEVELS; l++)
         if (depth_used[l] != 0) r.all_empty = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      disp_result_type got;
      disp_result_type want;
      if (reset) begin
         for (int l = 0; l < mlqd_pkg::NUM_LEVELS; l++) begin
            head_ptr[l] = '0;
            depth_used[l] = 0;
            slot_used[l] = 0;
         end
         for (int c = 0; c < mlqd_pkg::NUM_CPUS; c++) cursor[c] = 0;
         slot_inc = 1;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) slot_inc = int'(csr_wdata);
         if (req.valid && req.ready)
            expected_q.push_back(predict_dispatch(req.func, req.process_id,
                                                  req.priority_req, req.cpu_index));
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.found, rsp.granted_id, rsp.all_empty, rsp.enqueue_dropped};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result found=%0b id=%0d empty=%0b drop=%0b",
                        $time, got.found, got.granted_id, got.all_empty,
                        got.enqueue_dropped);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.found !== want.found) begin
                  $display("%0t: found exp %0b got %0b", $time, want.found, got.found);
                  fail_count++;
               end
               if (got.granted_id !== want.granted_id) begin
                  $display("%0t: granted_id exp %0d got %0d", $time, want.granted_id,
                           got.granted_id);
                  fail_count++;
               end
               if (got.all_empty !== want.all_empty) begin
                  $display("%0t: all_empty exp %0b got %0b", $time, want.all_empty,
                           got.all_empty);
                  fail_count++;
               end
               if (got.enqueue_dropped !== want.enqueue_dropped) begin
                  $display("%0t: enqueue_dropped exp %0b got %0b", $time,
                           want.enqueue_dropped, got.enqueue_dropped);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_q.size();
   end
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the multilevel queue dispatcher
// ----------------------------------------------------------------------------
// Directed items cover drops on full levels, priorities 0 and 7, all cpus,
// empty dispatch and extreme id values; random phases then mix enqueue and
// dispatch under several slot increments with bursty input and a stalling
// result side, including a long result hold-off and a full drain.
module tb;
   localparam int IDLE_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;
   int   sent_count = 0;
   int   rsp_count = 0;
   bit   hold_rsp = 1'b0;
   bit   dispatch_heavy = 1'b0;

   mlqd_req_if req ();
   mlqd_rsp_if rsp ();

   multilevel_queue_dispatcher_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req), .rsp(rsp)
   );

   mlqd_checker checker_i (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req), .rsp(rsp), .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side stall pattern, with an optional long hold-off
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp.ready <= 1'b0;
      else if ((sent_count / 200) % 2 == 1) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && ((req.valid && req.ready) || (rsp.valid && rsp.ready))) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp.valid && rsp.ready) rsp_count <= rsp_count + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic send_item(logic func, logic [7:0] pid, logic [2:0] prio, logic [1:0] cpu);
      req.valid <= 1'b1;
      req.func <= func;
      req.process_id <= pid;
      req.priority_req <= prio;
      req.cpu_index <= cpu;
      do @(posedge clock); while (!(req.valid && req.ready));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_increment(logic [7:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_burst(int n);
      int burst;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            if ($urandom_range(0, 2) == 0) pause_sender();
            burst = $urandom_range(1, 12);
         end
         burst--;
         if ($urandom_range(0, 99) < (dispatch_heavy ? 65 : 45))
            send_item(mlqd_pkg::FUNC_DISPATCH, 8'($urandom), 3'($urandom), 2'($urandom));
         else
            send_item(mlqd_pkg::FUNC_ENQUEUE, 8'($urandom), 3'($urandom), 2'($urandom));
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.func = mlqd_pkg::FUNC_ENQUEUE;
      req.process_id = '0;
      req.priority_req = '0;
      req.cpu_index = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      send_item(mlqd_pkg::FUNC_DISPATCH, 8'h00, 3'd0, 2'd0);
      for (int i = 0; i < mlqd_pkg::FIFO_DEPTH + 1; i++)
         send_item(mlqd_pkg::FUNC_ENQUEUE, (i == 0) ? 8'hff : i[7:0], 3'd7, 2'd3);
      send_item(mlqd_pkg::FUNC_ENQUEUE, 8'h00, 3'd0, 2'd0);
      send_item(mlqd_pkg::FUNC_ENQUEUE, 8'h5a, 3'd3, 2'd0);
      for (int c = 0; c < mlqd_pkg::NUM_CPUS; c++)
         send_item(mlqd_pkg::FUNC_DISPATCH, 8'hff, 3'd7, c[1:0]);
      drain_results();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: write_increment(8'd1);
            1: write_increment(8'd255);
            2: write_increment(8'd0);
            3: write_increment(8'd3);
            4: write_increment(8'd2);
            default: write_increment(8'($urandom_range(1, 255)));
         endcase
         dispatch_heavy = p[0];
         random_burst(100);
         // long receiver hold-off while requests keep coming
         if (p == 1) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (300) @(negedge clock);
                  hold_rsp = 1'b0;
               end
               random_burst(20);
            join
         end
         random_burst(60);
         drain_results();
      end

      $display("covered %0d requests, %0d results over six increment settings",
               sent_count, rsp_count);
      if (fail_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule
